### src/srdz_pkg.sv
// shared constants and types for the stick radial dead zone core
// no dependencies
package srdz_pkg;

   localparam int FULL_SCALE = 1000;
   localparam int DZ_MAX     = 999;
   localparam int AXIS_W     = 11;
   localparam int MAG_W      = 10;
   localparam int DZ_W       = 10;
   localparam int SQ_W       = 22;
   localparam int ROOT_W     = 11;
   localparam int REM_W      = 13;
   localparam int PROD_W     = 21;
   localparam int Q_W        = 16;
   localparam int OUT_W      = 16;
   localparam int ADDR_W     = 3;

   localparam logic [ADDR_W-1:0] ADDR_DEAD_ZONE = 3'd0;

   typedef struct packed {
      logic [MAG_W-1:0] mag_x;
      logic [MAG_W-1:0] mag_y;
      logic             neg_x;
      logic             neg_y;
      logic [DZ_W-1:0]  dz;
   } side_type;

   typedef struct packed {
      logic neg;
      logic zero;
      logic dz_hit;
   } meta_type;

endpackage

### src/srdz_sqrt.sv
// pipelined integer square root, one root bit per stage
// depends on srdz_pkg
module srdz_sqrt (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     en,
   input  logic                     in_valid,
   input  logic [srdz_pkg::SQ_W-1:0]   in_sq,
   input  srdz_pkg::side_type       in_side,
   output logic                     out_valid,
   output logic [srdz_pkg::ROOT_W-1:0] out_root,
   output srdz_pkg::side_type       out_side
);
   import srdz_pkg::*;

   logic              vld_ff  [ROOT_W];
   logic [SQ_W-1:0]   sq_ff   [ROOT_W];
   logic [REM_W-1:0]  rem_ff  [ROOT_W];
   logic [ROOT_W-1:0] root_ff [ROOT_W];
   side_type          side_ff [ROOT_W];

   for (genvar k = 0; k < ROOT_W; k++) begin : g_step
      logic              vld_i;
      logic [SQ_W-1:0]   sq_i;
      logic [REM_W-1:0]  rem_i;
      logic [ROOT_W-1:0] root_i;
      side_type          side_i;
      logic [REM_W+1:0]  cur;
      logic [REM_W+1:0]  trial;
      logic [REM_W-1:0]  rem_in;
      logic [ROOT_W-1:0] root_in;

      if (k == 0) begin : g_first
         assign vld_i  = in_valid;
         assign sq_i   = in_sq;
         assign rem_i  = '0;
         assign root_i = '0;
         assign side_i = in_side;
      end else begin : g_next
         assign vld_i  = vld_ff[k-1];
         assign sq_i   = sq_ff[k-1];
         assign rem_i  = rem_ff[k-1];
         assign root_i = root_ff[k-1];
         assign side_i = side_ff[k-1];
      end

      always_comb begin
         cur   = {rem_i, sq_i[SQ_W-1 -: 2]};
         trial = {{(REM_W+2-ROOT_W-2){1'b0}}, root_i, 2'b01};
         if (cur >= trial) begin
            rem_in  = REM_W'(cur - trial);
            root_in = {root_i[ROOT_W-2:0], 1'b1};
         end else begin
            rem_in  = cur[REM_W-1:0];
            root_in = {root_i[ROOT_W-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (en) begin
            vld_ff[k] <= vld_i;
         end
         if (en) begin
            sq_ff[k]   <= {sq_i[SQ_W-3:0], 2'b00};
            rem_ff[k]  <= rem_in;
            root_ff[k] <= root_in;
            side_ff[k] <= side_i;
         end
      end
   end

   assign out_valid = vld_ff[ROOT_W-1];
   assign out_root  = root_ff[ROOT_W-1];
   assign out_side  = side_ff[ROOT_W-1];

endmodule

### src/srdz_div.sv
// pipelined restoring divider, one quotient bit per stage, with overflow flag
// quotient of (prod << 14) / den; depends on srdz_pkg
module srdz_div (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      en,
   input  logic                      in_valid,
   input  srdz_pkg::meta_type        in_meta,
   input  logic [srdz_pkg::PROD_W-1:0] in_prod,
   input  logic [srdz_pkg::PROD_W-1:0] in_den,
   output logic                      out_valid,
   output srdz_pkg::meta_type        out_meta,
   output logic [srdz_pkg::Q_W-1:0]  out_q,
   output logic                      out_ovf
);
   import srdz_pkg::*;

   localparam int STAGES = Q_W + 1;

   logic              vld_ff  [STAGES];
   meta_type          meta_ff [STAGES];
   logic              ovf_ff  [STAGES];
   logic [PROD_W-1:0] den_ff  [STAGES];
   logic [PROD_W-1:0] rem_ff  [STAGES];
   logic [Q_W-1:0]    low_ff  [STAGES];
   logic [Q_W-1:0]    q_ff    [STAGES];

   // first stage: overflow test and initial remainder
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else if (en) begin
         vld_ff[0] <= in_valid;
      end
      if (en) begin
         meta_ff[0] <= in_meta;
         ovf_ff[0]  <= ({2'b00, in_prod[PROD_W-1:2]} >= in_den);
         den_ff[0]  <= in_den;
         rem_ff[0]  <= {2'b00, in_prod[PROD_W-1:2]};
         low_ff[0]  <= {in_prod[1:0], {(Q_W-2){1'b0}}};
         q_ff[0]    <= '0;
      end
   end

   for (genvar k = 1; k < STAGES; k++) begin : g_step
      logic [PROD_W:0]   cur;
      logic [PROD_W-1:0] rem_in;
      logic              qbit;

      always_comb begin
         cur  = {rem_ff[k-1], low_ff[k-1][Q_W-1]};
         qbit = (cur >= {1'b0, den_ff[k-1]});
         if (qbit) begin
            rem_in = PROD_W'(cur - {1'b0, den_ff[k-1]});
         end else begin
            rem_in = cur[PROD_W-1:0];
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (en) begin
            vld_ff[k] <= vld_ff[k-1];
         end
         if (en) begin
            meta_ff[k] <= meta_ff[k-1];
            ovf_ff[k]  <= ovf_ff[k-1];
            den_ff[k]  <= den_ff[k-1];
            rem_ff[k]  <= rem_in;
            low_ff[k]  <= {low_ff[k-1][Q_W-2:0], 1'b0};
            q_ff[k]    <= {q_ff[k-1][Q_W-2:0], qbit};
         end
      end
   end

   assign out_valid = vld_ff[STAGES-1];
   assign out_meta  = meta_ff[STAGES-1];
   assign out_q     = q_ff[STAGES-1];
   assign out_ovf   = ovf_ff[STAGES-1];

endmodule

### src/stick_radial_dead_zone_core.sv
// stick radial dead zone core: registers a and b, square root, c and d, divider, output register
// throughput one beat per cycle; the whole pipeline advances together and
// holds while a finished result waits on rsp_tready
// depth is set by the 11-stage square root and the 17-stage divider
// reset: synchronous, clears all valid bits, dead_zone returns to 100
module stick_radial_dead_zone_core (
   input  logic        clock,
   input  logic        reset,
   // config port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [srdz_pkg::ADDR_W-1:0] csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready,
   // input beats
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // axis_x[10:0], axis_y[21:11], zero fill
   // result beats
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // out_x[15:0], out_y[31:16]
   output logic        rsp_tuser    // inside_dead_zone
);
   import srdz_pkg::*;

   // pipeline moves when the output slot is empty or being drained
   logic en;

   // config register
   logic [DZ_W-1:0] dead_zone_ff;

   // stage a: clamped magnitudes
   logic             a_vld_ff;
   side_type         a_side_ff;
   // stage b: sum of squares
   logic             b_vld_ff;
   logic [SQ_W-1:0]  b_sq_ff;
   side_type         b_side_ff;
   // square root output
   logic              r_vld;
   logic [ROOT_W-1:0] r_root;
   side_type          r_side;
   // stage c: dead zone compare and differences
   logic              c_vld_ff;
   meta_type          c_mx_ff, c_my_ff;
   logic [MAG_W-1:0]  c_mag_x_ff, c_mag_y_ff;
   logic [ROOT_W-1:0] c_root_ff, c_rdiff_ff;
   logic [DZ_W-1:0]   c_fsd_ff;
   // stage d: products
   logic              d_vld_ff;
   meta_type          d_mx_ff, d_my_ff;
   logic [PROD_W-1:0] d_px_ff, d_py_ff, d_den_ff;
   // divider outputs
   logic              qx_vld, qy_vld, qx_ovf, qy_ovf;
   meta_type          qx_meta, qy_meta;
   logic [Q_W-1:0]    qx, qy;
   // output register
   logic              rsp_vld_ff;
   logic [OUT_W-1:0]  out_x_ff, out_y_ff, out_x_in, out_y_in;
   logic              dz_hit_ff;

   logic signed [AXIS_W-1:0] ax, ay;
   side_type                 a_side_in;

   assign en         = !rsp_vld_ff || rsp_tready;
   assign req_tready = en;

   // config port, always ready, single register
   assign csr_pready  = 1'b1;
   assign csr_prdata  = (csr_paddr == ADDR_DEAD_ZONE) ? {22'd0, dead_zone_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         dead_zone_ff <= DZ_W'(100);
      end else if (csr_psel && csr_penable && csr_pwrite && csr_paddr == ADDR_DEAD_ZONE) begin
         dead_zone_ff <= csr_pwdata[DZ_W-1:0];
      end
   end

   // clamp each axis to full scale, split into sign and magnitude
   function automatic logic [MAG_W-1:0] clamp_mag(input logic signed [AXIS_W-1:0] a);
      logic [MAG_W-1:0] m;
      if (a > AXIS_W'(FULL_SCALE) || a < -AXIS_W'(FULL_SCALE)) begin
         m = MAG_W'(FULL_SCALE);
      end else if (a < 0) begin
         m = MAG_W'(-a);
      end else begin
         m = MAG_W'(a);
      end
      return m;
   endfunction

   always_comb begin
      ax = req_tdata[AXIS_W-1:0];
      ay = req_tdata[2*AXIS_W-1:AXIS_W];
      a_side_in.mag_x = clamp_mag(ax);
      a_side_in.mag_y = clamp_mag(ay);
      a_side_in.neg_x = ax[AXIS_W-1];
      a_side_in.neg_y = ay[AXIS_W-1];
      // full scale over 1000 is one, so the dead zone is used directly
      a_side_in.dz    = (dead_zone_ff > DZ_W'(DZ_MAX)) ? DZ_W'(DZ_MAX) : dead_zone_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
         b_vld_ff <= 1'b0;
         c_vld_ff <= 1'b0;
         d_vld_ff <= 1'b0;
      end else if (en) begin
         a_vld_ff <= req_tvalid;
         b_vld_ff <= a_vld_ff;
         c_vld_ff <= r_vld;
         d_vld_ff <= c_vld_ff;
      end
      if (en) begin
         a_side_ff <= a_side_in;
         // stage b: squares and their sum
         b_sq_ff   <= SQ_W'(a_side_ff.mag_x * a_side_ff.mag_x)
                    + SQ_W'(a_side_ff.mag_y * a_side_ff.mag_y);
         b_side_ff <= a_side_ff;
         // stage c: compare against dead zone
         c_mx_ff.neg    <= r_side.neg_x;
         c_my_ff.neg    <= r_side.neg_y;
         c_mx_ff.dz_hit <= (r_root < ROOT_W'(r_side.dz));
         c_my_ff.dz_hit <= (r_root < ROOT_W'(r_side.dz));
         c_mx_ff.zero   <= (r_root < ROOT_W'(r_side.dz)) || (r_root == '0);
         c_my_ff.zero   <= (r_root < ROOT_W'(r_side.dz)) || (r_root == '0);
         c_mag_x_ff     <= r_side.mag_x;
         c_mag_y_ff     <= r_side.mag_y;
         c_root_ff      <= r_root;
         c_rdiff_ff     <= r_root - ROOT_W'(r_side.dz);
         c_fsd_ff       <= DZ_W'(FULL_SCALE) - r_side.dz;
         // stage d: numerators and common denominator
         d_mx_ff  <= c_mx_ff;
         d_my_ff  <= c_my_ff;
         d_px_ff  <= PROD_W'(c_mag_x_ff * c_rdiff_ff);
         d_py_ff  <= PROD_W'(c_mag_y_ff * c_rdiff_ff);
         d_den_ff <= PROD_W'(c_root_ff * c_fsd_ff);
      end
   end

   srdz_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (b_vld_ff),
      .in_sq     (b_sq_ff),
      .in_side   (b_side_ff),
      .out_valid (r_vld),
      .out_root  (r_root),
      .out_side  (r_side)
   );

   srdz_div u_div_x (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (d_vld_ff),
      .in_meta   (d_mx_ff),
      .in_prod   (d_px_ff),
      .in_den    (d_den_ff),
      .out_valid (qx_vld),
      .out_meta  (qx_meta),
      .out_q     (qx),
      .out_ovf   (qx_ovf)
   );

   srdz_div u_div_y (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (d_vld_ff),
      .in_meta   (d_my_ff),
      .in_prod   (d_py_ff),
      .in_den    (d_den_ff),
      .out_valid (qy_vld),
      .out_meta  (qy_meta),
      .out_q     (qy),
      .out_ovf   (qy_ovf)
   );

   // saturate to q2.14 and apply sign
   function automatic logic [OUT_W-1:0] sat_axis(input meta_type m, input logic ovf,
                                                 input logic [Q_W-1:0] q);
      logic [OUT_W:0]   mag;
      logic [OUT_W-1:0] r;
      if (m.zero) begin
         r = '0;
      end else if (m.neg) begin
         mag = (ovf || q > Q_W'(32768)) ? (OUT_W+1)'(32768) : {1'b0, q};
         r   = OUT_W'(~mag + 1'b1);
      end else begin
         r = (ovf || q > Q_W'(32767)) ? OUT_W'(32767) : q;
      end
      return r;
   endfunction

   assign out_x_in = sat_axis(qx_meta, qx_ovf, qx);
   assign out_y_in = sat_axis(qy_meta, qy_ovf, qy);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (en) begin
         rsp_vld_ff <= qx_vld && qy_vld;
      end
      if (en) begin
         out_x_ff  <= out_x_in;
         out_y_ff  <= out_y_in;
         dz_hit_ff <= qx_meta.dz_hit;
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = {out_y_ff, out_x_ff};
   assign rsp_tuser  = dz_hit_ff;

endmodule

### src/srdz_checker.sv
// port-level checks for the stick radial dead zone core
// depends on stick_radial_dead_zone_core ports; bound below
module srdz_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata,
   input logic        rsp_tuser
);
   a_dz_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata == 32'd0)
      else $error("dead zone result not zero");

   a_ready: assert property (@(posedge clock) disable iff (reset)
      req_tready == (!rsp_tvalid || rsp_tready))
      else $error("input ready does not follow output slot");

   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");
endmodule

bind stick_radial_dead_zone_core srdz_checker u_srdz_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

### dv/stick_radial_dead_zone_core_tb.sv
// self-checking testbench for the stick radial dead zone core
// depends on srdz_pkg and stick_radial_dead_zone_core
module stick_radial_dead_zone_core_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import srdz_pkg::*;

   typedef struct packed {
      logic [15:0] out_x;
      logic [15:0] out_y;
      logic        dz_hit;
   } stick_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [ADDR_W-1:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;   // axis_x[10:0], axis_y[21:11], zero fill
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;        // out_x[15:0], out_y[31:16]
   logic        rsp_tuser;        // inside_dead_zone

   stick_radial_dead_zone_core dut (.*);

   // clock: 10 ns period
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // testbench copy of the dead zone register
   logic [9:0] dz_setting = 10'd100;

   logic [21:0]      sample_queue[$];   // pending stick samples for the driver
   stick_result_type scaled_queue[$];   // expected results, oldest first
   int mismatches = 0;

   // side idling control
   bit calm_sender = 1'b0;
   bit calm_receiver = 1'b0;
   bit hold_active = 1'b0;   // forced receiver hold-off

   // ---------------------------------------------------------------
   // prediction
   // ---------------------------------------------------------------
   function automatic int clamp_axis(logic [10:0] raw);
      int a;
      a = $signed(raw);
      if (a > FULL_SCALE) a = FULL_SCALE;
      if (a < -FULL_SCALE) a = -FULL_SCALE;
      return a;
   endfunction

   function automatic longint floor_root(longint v);
      longint r;
      r = 0;
      while ((r + 1) * (r + 1) <= v) r++;
      return r;
   endfunction

   function automatic logic [15:0] rescale_axis(int a, longint r, longint dz);
      longint mag, q;
      mag = (a < 0) ? -a : a;
      q = (mag * (r - dz) * 16384) / (r * (FULL_SCALE - dz));
      if (a < 0) begin
         if (q > 32768) q = 32768;
         return 16'(-q);
      end
      if (q > 32767) q = 32767;
      return 16'(q);
   endfunction

   function automatic stick_result_type predict_stick(logic [21:0] sample, logic [9:0] dzreg);
      stick_result_type res;
      int x, y;
      longint dz, r;
      x = clamp_axis(sample[10:0]);
      y = clamp_axis(sample[21:11]);
      dz = (dzreg > DZ_MAX) ? DZ_MAX : dzreg;
      dz = dz * FULL_SCALE / 1000;
      r = floor_root(longint'(x) * x + longint'(y) * y);
      res = '0;
      if (r < dz) res.dz_hit = 1'b1;
      else if (r != 0) begin
         res.out_x = rescale_axis(x, r, dz);
         res.out_y = rescale_axis(y, r, dz);
      end
      return res;
   endfunction

   // ---------------------------------------------------------------
   // driver: offers queued samples, idles at random
   // ---------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            scaled_queue.push_back(predict_stick(req_tdata[21:0], dz_setting));
            void'(sample_queue.pop_front());
         end
         // decide on the beat for the next edge, one assignment per step
         if ((req_tvalid && req_tready) || !req_tvalid) begin
            if (sample_queue.size() > 0 &&
                (calm_sender || $urandom_range(99) >= 12)) begin
               req_tvalid <= 1'b1;
               req_tdata  <= {2'b00, sample_queue[0]};
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------
   // monitor and receiver
   // ---------------------------------------------------------------
   always @(posedge clock) begin
      stick_result_type got, want;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got = {rsp_tdata[15:0], rsp_tdata[31:16], rsp_tuser};
            if (scaled_queue.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected result beat %h", got);
            end else begin
               want = scaled_queue.pop_front();
               if (got !== want) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: x exp %h got %h, y exp %h got %h, dz exp %b got %b",
                              want.out_x, got.out_x, want.out_y, got.out_y,
                              want.dz_hit, got.dz_hit);
               end
            end
         end
         if (hold_active) begin
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= calm_receiver || ($urandom_range(99) >= 12);
         end
      end
   end

   // ---------------------------------------------------------------
   // stimulus helpers
   // ---------------------------------------------------------------
   task automatic queue_sample(int x, int y);
      sample_queue.push_back({11'(y), 11'(x)});
   endtask

   task automatic wait_drained();
      while (sample_queue.size() != 0 || req_tvalid || scaled_queue.size() != 0)
         @(posedge clock);
   endtask

   // write the dead zone register; only while the core is idle
   task automatic write_dead_zone(logic [9:0] value);
      wait_drained();
      repeat (40) @(posedge clock);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_paddr <= ADDR_DEAD_ZONE;
      csr_pwdata <= {$urandom()} & 32'hFFFF_FC00 | value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      dz_setting = value;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(posedge clock);
   endtask

   // mostly in range, sometimes any raw 11-bit code to hit the clamp
   function automatic int rand_axis();
      case ($urandom_range(9))
         0: return int'($signed(11'($urandom())));
         1: return $urandom_range(1) ? 1000 : -1000;
         2: return int'($urandom_range(40)) - 20;
         default: return int'($urandom_range(2000)) - 1000;
      endcase
   endfunction

   task automatic random_block(int n);
      for (int i = 0; i < n; i++) queue_sample(rand_axis(), rand_axis());
   endtask

   // ---------------------------------------------------------------
   // main sequence
   // ---------------------------------------------------------------
   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: zero, tiny radius, full-scale axes, corners, raw extremes
      queue_sample(0, 0);
      queue_sample(3, -4);
      queue_sample(1000, 0);
      queue_sample(-1000, 0);
      queue_sample(0, 1000);
      queue_sample(0, -1000);
      queue_sample(1000, 1000);
      queue_sample(-1000, -1000);
      queue_sample(1000, -1000);
      queue_sample(1023, -1024);
      queue_sample(-1024, 1023);
      queue_sample(1001, -1001);
      queue_sample(99, 0);
      queue_sample(100, 0);
      queue_sample(60, 80);
      queue_sample(-707, 707);
      wait_drained();

      // zero dead zone: zero radius takes no division
      write_dead_zone(10'd0);
      queue_sample(0, 0);
      queue_sample(1, 0);
      queue_sample(-1024, -1024);
      queue_sample(1000, 1000);
      random_block(60);

      // receiver holds off for a long stretch while the sender keeps going
      wait_drained();
      calm_sender = 1'b1;
      fork
         begin
            hold_active <= 1'b1;
            repeat (120) @(posedge clock);
            hold_active <= 1'b0;
         end
      join_none
      random_block(80);
      wait_drained();
      calm_sender = 1'b0;

      // dead zone above range saturates to 999
      write_dead_zone(10'd1023);
      queue_sample(999, 0);
      queue_sample(1000, 0);
      queue_sample(1000, 1000);
      random_block(40);

      write_dead_zone(10'd999);
      random_block(50);

      // stretch without idling on either side
      write_dead_zone(10'($urandom_range(999)));
      calm_sender = 1'b1;
      calm_receiver = 1'b1;
      random_block(100);
      wait_drained();
      calm_sender = 1'b0;
      calm_receiver = 1'b0;

      write_dead_zone(10'd512);
      random_block(80);
      write_dead_zone(10'd100);
      random_block(80);

      wait_drained();
      repeat (60) @(posedge clock);
      if (mismatches == 0 && scaled_queue.size() == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

   // watchdog
   initial begin
      #2ms;
      $display("Test completed with failures");
      $finish;
   end

endmodule

### sim.f
src/srdz_pkg.sv
src/srdz_sqrt.sv
src/srdz_div.sv
src/stick_radial_dead_zone_core.sv
src/srdz_checker.sv
dv/stick_radial_dead_zone_core_tb.sv
